// ===== rtl/sbc_pkg.sv =====
// sbc_pkg: shared types and constants for the single-byte charset to UTF-8 converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package sbc_pkg;

    // charset_mode codes
    localparam logic [1:0] MODE_LATIN1 = 2'd0;
    localparam logic [1:0] MODE_LATIN9 = 2'd1;
    localparam logic [1:0] MODE_CP1252 = 2'd2;
    localparam logic [1:0] MODE_PASS   = 2'd3;

    // UTF-8 length thresholds and lead/continuation markers
    localparam logic [15:0] CP_ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] CP_TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [7:0]  LEAD2_MARK        = 8'hC0;
    localparam logic [7:0]  LEAD3_MARK        = 8'hE0;
    localparam logic [7:0]  CONT_MARK         = 8'h80;

    // byte-count codes, stored as length minus one
    localparam logic [1:0] LEN_ONE   = 2'd0;
    localparam logic [1:0] LEN_TWO   = 2'd1;
    localparam logic [1:0] LEN_THREE = 2'd2;

    // Windows-1252 range 0x80..0x9F
    localparam logic [7:0] CP1252_LO = 8'h80;
    localparam logic [7:0] CP1252_HI = 8'h9F;

    localparam logic [15:0] CP1252_HIGH [32] = '{
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       char_done;
        logic       text_done;
    } t_out_item;

    // one encoded character waiting between front and back
    typedef struct packed {
        logic [2:0][7:0] bytes;   // bytes[0] goes out first
        logic [1:0]      len_m1;  // number of bytes minus one
        logic            eot;
    } t_sbc_entry;

endpackage

`default_nettype wire

// ===== rtl/single_byte_charset_to_utf8.sv =====
// single_byte_charset_to_utf8: top level of the charset to UTF-8 converter.
// Depends on sbc_pkg, sbc_front, sbc_queue, sbc_back.
//
// Usage:
//  - Input side is a queue write port: a transfer happens on a rising edge with
//    push high and full low; i_in_item carries text_byte and end_of_text.
//  - Output side is a queue read port: while empty is low, o_out_item holds the
//    oldest UTF-8 byte; a transfer happens on a rising edge with pop high.
//  - Config: i_cfg_valid/o_cfg_ready write charset_mode (0 Latin-1, 1 Latin-9,
//    2 Windows-1252, 3 pass-through). Ready is always high; write only when idle.
//  - A pushed byte is stored in the queue, then loaded into the output register.
//  - Throughput: the output register drains one byte per cycle while pop is high;
//    an input byte yields 1 to 3 bytes (its UTF-8 length). The front encodes one
//    byte a cycle into a QDEPTH-entry queue, so full rises only when the back lags.
//  - A stalled receiver holds the output register; the queue keeps filling
//    until full, then push is held off. No transfer is lost or repeated.
//  - Synchronous active-low reset empties the queue and output register and
//    sets charset_mode to pass-through.
`default_nettype none

module single_byte_charset_to_utf8
    import sbc_pkg::*;
#(
    parameter int QDEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       push,
    output logic            full,
    input  wire t_in_item   i_in_item,
    // result channel
    output logic            empty,
    input  wire logic       pop,
    output t_out_item       o_out_item,
    // configuration
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_data
);

    logic [1:0] r_mode;
    t_sbc_entry enc_entry;
    t_sbc_entry q_head;
    logic       q_empty, q_rd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PASS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // front: charset lookup and UTF-8 encode
    sbc_front u_front (
        .i_mode  (r_mode),
        .i_item  (i_in_item),
        .o_entry (enc_entry)
    );

    // decoupling queue
    sbc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (push),
        .i_wr_entry (enc_entry),
        .i_rd       (q_rd),
        .o_head     (q_head),
        .o_empty    (q_empty),
        .o_full     (full)
    );

    // back: byte serializer and output register
    sbc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .empty     (empty),
        .pop       (pop),
        .o_item    (o_out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/sbc_front.sv =====
// sbc_front: maps a source byte to a code point and encodes it as UTF-8 bytes.
// Depends on sbc_pkg.
`default_nettype none

module sbc_front
    import sbc_pkg::*;
(
    input  wire logic [1:0] i_mode,
    input  wire t_in_item   i_item,
    output t_sbc_entry      o_entry
);

    function automatic logic [15:0] latin9_point(input logic [7:0] b);
        logic [15:0] cp;
        begin
            case (b)
                8'hA4:   cp = 16'h20AC;
                8'hA6:   cp = 16'h0160;
                8'hA8:   cp = 16'h0161;
                8'hB4:   cp = 16'h017D;
                8'hB8:   cp = 16'h017E;
                8'hBC:   cp = 16'h0152;
                8'hBD:   cp = 16'h0153;
                8'hBE:   cp = 16'h0178;
                default: cp = {8'h00, b};
            endcase
            return cp;
        end
    endfunction

    logic [15:0] cp;
    logic [7:0]  b;

    assign b = i_item.text_byte;

    always_comb begin
        case (i_mode)
            MODE_LATIN9: cp = latin9_point(b);
            MODE_CP1252: begin
                if (b >= CP1252_LO && b <= CP1252_HI) begin
                    cp = CP1252_HIGH[b[4:0]];
                end else begin
                    cp = {8'h00, b};
                end
            end
            default:     cp = {8'h00, b};
        endcase
    end

    always_comb begin
        o_entry.eot   = i_item.end_of_text;
        o_entry.bytes = '0;
        if (i_mode == MODE_PASS) begin
            o_entry.bytes[0] = b;
            o_entry.len_m1   = LEN_ONE;
        end else if (cp < CP_ONE_BYTE_LIMIT) begin
            o_entry.bytes[0] = cp[7:0];
            o_entry.len_m1   = LEN_ONE;
        end else if (cp < CP_TWO_BYTE_LIMIT) begin
            o_entry.bytes[0] = LEAD2_MARK | {3'b000, cp[10:6]};
            o_entry.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
            o_entry.len_m1   = LEN_TWO;
        end else begin
            o_entry.bytes[0] = LEAD3_MARK | {4'h0, cp[15:12]};
            o_entry.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
            o_entry.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
            o_entry.len_m1   = LEN_THREE;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sbc_queue.sv =====
// sbc_queue: small FIFO of encoded characters between front and back.
// Depends on sbc_pkg.
`default_nettype none

module sbc_queue
    import sbc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_wr,
    input  wire t_sbc_entry i_wr_entry,
    input  wire logic       i_rd,
    output t_sbc_entry      o_head,
    output logic            o_empty,
    output logic            o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_sbc_entry    r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_wr, do_rd;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FULL_CNT);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sbc_back.sv =====
// sbc_back: serializes queued UTF-8 characters into an output register, one byte per cycle while pop keeps it free.
// Depends on sbc_pkg.
`default_nettype none

module sbc_back
    import sbc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_sbc_entry i_head,
    input  wire logic       i_q_empty,
    output logic            o_q_rd,
    output logic            empty,
    input  wire logic       pop,
    output t_out_item       o_item
);

    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out;
    logic       load, last;
    logic [7:0] sel_byte;

    // output register frees up when empty or being drained this cycle
    assign load = !i_q_empty && (!r_out_valid || pop);
    assign last = (r_idx == i_head.len_m1);
    assign o_q_rd = load && last;

    always_comb begin
        case (r_idx)
            LEN_ONE:  sel_byte = i_head.bytes[0];
            LEN_TWO:  sel_byte = i_head.bytes[1];
            default:  sel_byte = i_head.bytes[2];
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
            n_idx       = last ? '0 : r_idx + 1'b1;
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.utf8_byte <= sel_byte;
            r_out.char_done <= last;
            r_out.text_done <= last && i_head.eot;
        end
    end

    assign empty  = !r_out_valid;
    assign o_item = r_out;

endmodule

`default_nettype wire
